// ----- hdl/glq_pkg.sv -----
// Shared types and constants for the glyph quad layout block.
`timescale 1ns / 1ps

package glq_pkg;

	localparam int GLYPH_COUNT = 256;
	localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);

	localparam int DIVIDEND_W  = 16;
	localparam int DIVISOR_W   = 13;
	localparam int REMAINDER_W = 12;
	localparam int DIV_CNT_W   = $clog2(DIVIDEND_W);

	localparam logic [7:0]  NEWLINE_CODE = 8'd10;
	localparam logic [12:0] AW_MIN       = 13'd1;
	localparam logic [12:0] AW_MAX       = 13'd4096;

	typedef enum logic [2:0] {
		REG_ATLAS_WIDTH  = 3'd0,
		REG_ATLAS_HEIGHT = 3'd1,
		REG_CELL_WIDTH   = 3'd2,
		REG_CELL_HEIGHT  = 3'd3,
		REG_FIRST_CODE   = 3'd4,
		REG_ORIGIN_X     = 3'd5,
		REG_ORIGIN_Y     = 3'd6
	} cfg_reg_t;

	typedef enum logic {
		ACT_LOAD_WIDTH = 1'b0,
		ACT_CHARACTER  = 1'b1
	} action_t;

	typedef struct packed {
		logic       action;
		logic [7:0] char_code;
		logic [7:0] glyph_width;
		logic       string_start;
	} in_word_t;

	typedef struct packed {
		logic               quad_valid;
		logic signed [15:0] screen_x0;
		logic signed [15:0] screen_y0;
		logic signed [15:0] screen_x1;
		logic signed [15:0] screen_y1;
		logic [11:0]        atlas_u0;
		logic [23:0]        atlas_v0;
		logic [12:0]        atlas_u1;
		logic [23:0]        atlas_v1;
		logic [15:0]        pen_offset;
	} out_word_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- hdl/glyph_quad_layout_unit.sv -----
// Top level of the glyph quad layout block: width table, pen state and quad build.
`timescale 1ns / 1ps
// Flow: a character word walks the load, divide, scale and done states before its quad
// is registered at the output; a newline goes from idle straight to done. A width-table
// write gives no output. A new word is taken only once the last one has left the done
// state, so the 16-step bit-serial divider sets the character rate; a held output stalls it.
// Reset: pen, line offset, control and registers return to defaults; the width table
// is not cleared and holds unknown values until written.

module glyph_quad_layout_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  glq_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output glq_pkg::out_word_t out_word,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import glq_pkg::*;

	// Sequencer states. A character walks IDLE, LOAD, DIV, SCALE, DONE; a newline
	// jumps straight from IDLE to DONE since it needs no atlas lookup.
	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_SCALE,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers. The atlas height only feeds normalization in the
	// original software, so a write to it is accepted and dropped.
	logic [12:0]        atlas_w_q;
	logic [7:0]         cell_w_q;
	logic [7:0]         cell_h_q;
	logic [7:0]         first_code_q;
	logic signed [15:0] origin_x_q;
	logic signed [15:0] origin_y_q;

	// Layout state.
	logic [15:0] pen_q;
	logic [15:0] line_q;

	// Item held for the duration of its work.
	in_word_t    item_q;
	logic [15:0] t_q;
	logic [7:0]  wrd_q;
	logic        wrd_ok_q;
	logic [23:0] v0_q;

	out_word_t out_q;
	logic      out_valid_q;

	logic [7:0] width_mem [GLYPH_COUNT];

	logic        accept;
	logic        in_range;
	logic [7:0]  cell_idx;
	logic [12:0] aw_clamped;
	logic [15:0] div_q;
	logic [11:0] div_r;
	div_stat_t   div_stat;
	logic        out_free;

	logic [15:0]        pen_eff;
	logic [15:0]        line_eff;
	logic [7:0]         w_eff;
	logic signed [17:0] x0_full;
	logic signed [17:0] y0_full;
	logic signed [17:0] x1_full;
	logic signed [17:0] y1_full;
	logic [16:0]        pen_sum;
	logic [16:0]        line_sum;
	logic [15:0]        pen_next;
	logic [15:0]        line_next;

	function automatic logic signed [15:0] sat_s16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic [15:0] sat_u16(input logic [16:0] v);
		return v[16] ? 16'hFFFF : v[15:0];
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = (int'(in_word.char_code) < GLYPH_COUNT);
	assign cell_idx = in_word.char_code - first_code_q;
	assign out_free = !out_valid_q || out_ready;

	// A zero atlas width is treated as one; the register cannot exceed 8191, so
	// anything above 4096 is pulled down to 4096.
	always_comb begin
		aw_clamped = atlas_w_q;
		if (atlas_w_q < AW_MIN) begin
			aw_clamped = AW_MIN;
		end else if (atlas_w_q > AW_MAX) begin
			aw_clamped = AW_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_w_q    <= 13'd256;
			cell_w_q     <= 8'd8;
			cell_h_q     <= 8'd16;
			first_code_q <= 8'd32;
			origin_x_q   <= '0;
			origin_y_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATLAS_WIDTH:  atlas_w_q    <= cfg_data[12:0];
				REG_ATLAS_HEIGHT: ;
				REG_CELL_WIDTH:   cell_w_q     <= cfg_data[7:0];
				REG_CELL_HEIGHT:  cell_h_q     <= cfg_data[7:0];
				REG_FIRST_CODE:   first_code_q <= cfg_data[7:0];
				REG_ORIGIN_X:     origin_x_q   <= cfg_data;
				REG_ORIGIN_Y:     origin_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Width table: one write or one registered read per accepted word.
	always_ff @(posedge clk) begin
		if (accept) begin
			if (in_word.action == ACT_LOAD_WIDTH) begin
				if (in_range) begin
					width_mem[in_word.char_code[GLYPH_AW-1:0]] <= in_word.glyph_width;
				end
			end else begin
				wrd_q <= width_mem[in_word.char_code[GLYPH_AW-1:0]];
			end
		end
	end

	// Atlas index and the item itself are captured on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= in_word;
			wrd_ok_q <= in_range;
			t_q      <= {8'b0, cell_w_q} * {8'b0, cell_idx};
		end
		if (state_q == S_SCALE) begin
			v0_q <= {8'b0, div_q} * {16'b0, cell_h_q};
		end
	end

	glq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_LOAD),
		.dividend  (t_q),
		.divisor   (aw_clamped),
		.quotient  (div_q),
		.remainder (div_r),
		.stat      (div_stat)
	);

	// Quad assembly. A string start zeroes the pen and line before this word.
	always_comb begin
		pen_eff   = item_q.string_start ? 16'd0 : pen_q;
		line_eff  = item_q.string_start ? 16'd0 : line_q;
		w_eff     = wrd_ok_q ? wrd_q : 8'd0;
		x0_full   = {{2{origin_x_q[15]}}, origin_x_q} + {2'b00, pen_eff};
		y0_full   = {{2{origin_y_q[15]}}, origin_y_q} + {2'b00, line_eff};
		x1_full   = x0_full + {10'b0, w_eff};
		y1_full   = y0_full + {10'b0, cell_h_q};
		pen_sum   = {1'b0, pen_eff} + {9'b0, w_eff};
		line_sum  = {1'b0, line_eff} + {9'b0, cell_h_q};
		pen_next  = sat_u16(pen_sum);
		line_next = sat_u16(line_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pen_q       <= '0;
			line_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// In DONE the output register is either refilled or left holding.
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && in_word.action == ACT_CHARACTER) begin
						state_q <= (in_word.char_code == NEWLINE_CODE) ? S_DONE : S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (item_q.char_code == NEWLINE_CODE) begin
							// A newline returns the pen and moves down one cell.
							out_q  <= '0;
							pen_q  <= '0;
							line_q <= line_next;
						end else begin
							out_q.quad_valid <= 1'b1;
							out_q.screen_x0  <= sat_s16(x0_full);
							out_q.screen_y0  <= sat_s16(y0_full);
							out_q.screen_x1  <= sat_s16(x1_full);
							out_q.screen_y1  <= sat_s16(y1_full);
							out_q.atlas_u0   <= div_r;
							out_q.atlas_v0   <= v0_q;
							out_q.atlas_u1   <= {1'b0, div_r} + {5'b0, w_eff};
							out_q.atlas_v1   <= v0_q + {16'b0, cell_h_q};
							out_q.pen_offset <= pen_next;
							pen_q            <= pen_next;
							line_q           <= line_eff;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// The divider only runs while a character is in flight.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_stat.busy)
		else $error("divider busy while the sequencer is idle");

	// A finished division leaves a remainder below the clamped atlas width.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_stat.done) |-> ({1'b0, div_r} < aw_clamped))
		else $error("divider remainder not below the atlas width");

	// A width-table write never starts the sequencer.
	a_load_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_word.action == ACT_LOAD_WIDTH) |=> state_q == S_IDLE)
		else $error("width write left the idle state");

	// A newline word always reports a pen back at the line start.
	a_newline_pen: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.quad_valid) |-> out_word.pen_offset == 16'd0)
		else $error("newline word with a nonzero pen offset");

endmodule

// ----- hdl/glq_div.sv -----
// Bit-serial restoring divider: one quotient bit per clock.
`timescale 1ns / 1ps

module glq_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [glq_pkg::DIVIDEND_W-1:0]      dividend,
	input  logic [glq_pkg::DIVISOR_W-1:0]       divisor,
	output logic [glq_pkg::DIVIDEND_W-1:0]      quotient,
	output logic [glq_pkg::REMAINDER_W-1:0]     remainder,
	output glq_pkg::div_stat_t                  stat
);
	import glq_pkg::*;

	logic [DIVIDEND_W-1:0]  num_q;
	logic [REMAINDER_W-1:0] rem_q;
	logic [DIVISOR_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [REMAINDER_W:0]   shifted;
	logic [REMAINDER_W:0]   diff;
	logic                   fits;

	// The partial remainder stays below the divisor, which is at most 4096.
	assign shifted = {rem_q, num_q[DIVIDEND_W-1]};
	assign fits    = ({1'b0, shifted} >= {1'b0, dsr_q});
	assign diff    = shifted - dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[REMAINDER_W-1:0] : shifted[REMAINDER_W-1:0];
		end
	end

	assign quotient  = num_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
